FILE: rtl/core/gpio_bank_with_pin_interrupts_assert.svh
// Assertion macros used by the checker of the GPIO bank.
`ifndef GPIO_BANK_WITH_PIN_INTERRUPTS_ASSERT_SVH
`define GPIO_BANK_WITH_PIN_INTERRUPTS_ASSERT_SVH

// same-cycle implication, off while reset is held
`define GBPI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gbpi assertion failed");

// next-cycle implication, off while reset is held
`define GBPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gbpi assertion failed");

// next-cycle implication that also covers reset
`define GBPI_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("gbpi reset assertion failed");

`endif

FILE: rtl/core/gbpi_pkg.sv
// Package with request codes, status codes, entry layout and stage structs of the GPIO bank.
package gbpi_pkg;

    typedef enum logic [2:0] {
        REQ_LVL_RD  = 3'd0,
        REQ_LVL_WR  = 3'd1,
        REQ_CONF_RD = 3'd2,
        REQ_CONF_WR = 3'd3,
        REQ_PIN_EVT = 3'd4
    } t_req_code;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_LEVEL    = 2'd1,
        ST_PULL_REFUSED = 2'd2
    } t_status;

    localparam logic [1:0] LVL_LOW     = 2'd1;
    localparam logic [1:0] LVL_HIGH    = 2'd2;
    localparam logic [1:0] LVL_ILLEGAL = 2'd3;
    localparam logic [7:0] LVL_MAX     = 8'd2;

    localparam int CONF_PULLUP_BIT     = 1;
    localparam int CONF_PULLDOWN_BIT   = 2;
    localparam int CONF_INT_LVL_LOW    = 3;
    localparam int CONF_INT_LVL_HIGH   = 4;
    localparam int CONF_INT_EDGE_LOW   = 5;
    localparam int CONF_INT_EDGE_HIGH  = 6;
    localparam logic [7:0] CONF_PULL_MASK = 8'h06;

    typedef struct packed {
        logic [2:0] req_type;
        logic [3:0] pin_index;
        logic [7:0] write_data;
        logic [1:0] pin_level;
    } t_req_item;

    typedef struct packed {
        logic [7:0] conf;
        logic [1:0] level;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_entry data;
    } t_wb;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_fire;
        logic [3:0] irq_line;
        logic [1:0] status;
    } t_result;

endpackage

FILE: rtl/core/gbpi_if.sv
// Request and response channel interfaces of the GPIO bank.
interface gbpi_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [3:0] pin_index;
    logic [7:0] write_data;
    logic [1:0] pin_level;

    modport source (output valid, req_type, pin_index, write_data, pin_level, input ready);
    modport sink (input valid, req_type, pin_index, write_data, pin_level, output ready);
    modport monitor (input valid, ready, req_type, pin_index, write_data, pin_level);
endinterface

interface gbpi_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_fire;
    logic [3:0] irq_line;
    logic [1:0] status;

    modport source (output valid, read_data, irq_fire, irq_line, status, input ready);
    modport sink (input valid, read_data, irq_fire, irq_line, status, output ready);
    modport monitor (input valid, ready, read_data, irq_fire, irq_line, status);
endinterface

FILE: rtl/core/gbpi_pin_ram.sv
// Per-pin state memory: level and configuration, registered read, write forwarding, valid bits.
module gbpi_pin_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  gbpi_pkg::t_entry  i_wdata,
    output gbpi_pkg::t_entry  o_rdata
);
    import gbpi_pkg::*;

    t_entry           r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_entry           r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // forward a write that lands on the entry being read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else if (r_valid[i_raddr]) begin
                r_rdata <= r_mem[i_raddr];
            end else begin
                r_rdata <= '0;
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/gbpi_rmw.sv
// Modify step: decodes a request against the pin entry, builds the result and the write-back.
module gbpi_rmw (
    input  gbpi_pkg::t_req_item i_req,
    input  gbpi_pkg::t_entry    i_entry,
    input  logic                i_in_range,
    input  logic                i_coalesce,
    output gbpi_pkg::t_result   o_res,
    output gbpi_pkg::t_wb       o_wb
);
    import gbpi_pkg::*;

    logic hit;

    always_comb begin
        o_res   = '0;
        o_wb.we = 1'b0;
        o_wb.data = i_entry;
        hit = 1'b0;
        if (i_in_range) begin
            case (i_req.req_type)
                REQ_LVL_RD: begin
                    o_res.read_data = {6'd0, i_entry.level};
                end
                REQ_LVL_WR: begin
                    if (i_req.write_data > LVL_MAX) begin
                        o_res.status = ST_BAD_LEVEL;
                    end else begin
                        o_wb.we = 1'b1;
                        o_wb.data.level = i_req.write_data[1:0];
                    end
                end
                REQ_CONF_RD: begin
                    o_res.read_data = i_entry.conf;
                end
                REQ_CONF_WR: begin
                    if (((i_entry.conf ^ i_req.write_data) & CONF_PULL_MASK) != 8'd0) begin
                        o_res.status = ST_PULL_REFUSED;
                    end else begin
                        o_wb.we = 1'b1;
                        o_wb.data.conf = i_req.write_data;
                    end
                end
                REQ_PIN_EVT: begin
                    if (i_req.pin_level == LVL_ILLEGAL) begin
                        o_res.status = ST_BAD_LEVEL;
                    end else begin
                        o_wb.we = 1'b1;
                        o_wb.data.level = i_req.pin_level;
                        if (i_req.pin_level == LVL_LOW) begin
                            hit = i_entry.conf[CONF_INT_LVL_LOW]
                                || (i_entry.level != LVL_LOW
                                    && i_entry.conf[CONF_INT_EDGE_LOW]);
                        end else if (i_req.pin_level == LVL_HIGH) begin
                            hit = i_entry.conf[CONF_INT_LVL_HIGH]
                                || (i_entry.level != LVL_HIGH
                                    && i_entry.conf[CONF_INT_EDGE_HIGH]);
                        end
                        o_res.irq_fire = hit;
                        o_res.irq_line = (hit && !i_coalesce) ? i_req.pin_index : 4'd0;
                    end
                end
                default: begin
                    o_res = '0;
                end
            endcase
        end
    end
endmodule

FILE: rtl/core/gpio_bank_with_pin_interrupts.sv
// Top level of the GPIO bank with per-pin level and edge interrupts.
// Usage:
//   i_req carries bus requests (level read/write, conf read/write) and external
//   pin events; o_rsp returns exactly one response per request, in order.
//   i_cfg_we/i_cfg_wdata[0] set the coalesce mode; write it only while idle.
// Pipeline: the pin entry is read from memory as the request is taken; modify
//   and write-back follow, and the result is registered in the output register.
// Throughput: one request per cycle while o_rsp.ready is high. The pin memory
//   has one read and one write port; a request that reads the entry being
//   written in the same cycle gets the written value forwarded.
// Reset: synchronous, active low. All pin levels and configurations read as
//   zero until written, coalesce mode is off, no response is pending.
// Stall: the response sits in an output register; while o_rsp.ready is low a
//   second request can wait in the modify stage, after which i_req.ready drops.
module gpio_bank_with_pin_interrupts #(
    parameter int PIN_COUNT = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    gbpi_req_if.sink         i_req,
    gbpi_rsp_if.source       o_rsp
);
    import gbpi_pkg::*;

    localparam int PIN_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

    logic      r_coalesce;
    logic      r_busy, n_busy;
    t_req_item r_req;
    logic      r_out_valid, n_out_valid;
    t_result   r_out;

    logic      accept, out_free, finish, in_range;
    t_entry    rd_entry;
    t_result   res;
    t_wb       wb;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign finish   = r_busy && out_free;
    assign i_req.ready = !r_busy || finish;
    assign in_range = 32'(r_req.pin_index) < PIN_COUNT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coalesce <= 1'b0;
        end else if (i_cfg_we) begin
            r_coalesce <= i_cfg_wdata;
        end
    end

    gbpi_pin_ram #(
        .DEPTH (PIN_COUNT),
        .AW    (PIN_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (accept),
        .i_raddr (PIN_W'(i_req.pin_index)),
        .i_we    (finish && wb.we),
        .i_waddr (PIN_W'(r_req.pin_index)),
        .i_wdata (wb.data),
        .o_rdata (rd_entry)
    );

    gbpi_rmw u_rmw (
        .i_req      (r_req),
        .i_entry    (rd_entry),
        .i_in_range (in_range),
        .i_coalesce (r_coalesce),
        .o_res      (res),
        .o_wb       (wb)
    );

    always_comb begin
        n_busy = r_busy;
        if (accept) begin
            n_busy = 1'b1;
        end else if (finish) begin
            n_busy = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.req_type   <= i_req.req_type;
            r_req.pin_index  <= i_req.pin_index;
            r_req.write_data <= i_req.write_data;
            r_req.pin_level  <= i_req.pin_level;
        end
        if (finish) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out.read_data;
    assign o_rsp.irq_fire  = r_out.irq_fire;
    assign o_rsp.irq_line  = r_out.irq_line;
    assign o_rsp.status    = r_out.status;
endmodule

FILE: rtl/core/gbpi_checker.sv
// Port-level checker for the GPIO bank and its bind to the top level.
`include "gpio_bank_with_pin_interrupts_assert.svh"

module gbpi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [7:0] i_rsp_read_data,
    input logic       i_rsp_irq_fire,
    input logic [3:0] i_rsp_irq_line,
    input logic [1:0] i_rsp_status
);
    import gbpi_pkg::*;

    logic [14:0] rsp_payload;

    assign rsp_payload = {i_rsp_read_data, i_rsp_irq_fire, i_rsp_irq_line, i_rsp_status};

    `GBPI_ASSERT_RST(a_rst_clears_rsp, !i_rst_n, !i_rsp_valid)
    `GBPI_ASSERT_NOW(a_irq_status_ok, i_rsp_valid && i_rsp_irq_fire, i_rsp_status == ST_OK)
    `GBPI_ASSERT_NOW(a_irq_no_rdata, i_rsp_valid && i_rsp_irq_fire, i_rsp_read_data == 8'd0)
    `GBPI_ASSERT_NOW(a_line_zero_no_irq, i_rsp_valid && !i_rsp_irq_fire, i_rsp_irq_line == 4'd0)
    `GBPI_ASSERT_NEXT(a_stall_holds, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(rsp_payload))
endmodule

bind gpio_bank_with_pin_interrupts gbpi_checker u_gbpi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_read_data (o_rsp.read_data),
    .i_rsp_irq_fire  (o_rsp.irq_fire),
    .i_rsp_irq_line  (o_rsp.irq_line),
    .i_rsp_status    (o_rsp.status)
);

FILE: tb/gpio_bank_with_pin_interrupts_tb.sv
// Self-checking testbench of the GPIO bank: directed and random requests checked against a predictor.
module gpio_bank_with_pin_interrupts_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbpi_pkg::*;

    localparam int PINS = 16;
    localparam int RSP_LATENCY = 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int MAX_SHOWN = 10;
    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
    localparam logic [1:0] LVL_FLOAT = 2'd0;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;

    gbpi_req_if req_ch();
    gbpi_rsp_if rsp_ch();

    gpio_bank_with_pin_interrupts #(
        .PIN_COUNT(PINS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    logic [1:0] pin_level_q[PINS];
    logic [7:0] pin_conf_q[PINS];
    logic       coalesce_q;
    t_result    pending_responses[$];
    int         errors = 0;
    int         cycles = 0;
    int         rsp_stall_left = 0;
    bit         no_idle;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ch.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            rsp_stall_left = $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_responses.size() == 0) begin
                if (errors < MAX_SHOWN)
                    $display("unexpected response: rdata=%0h fire=%0b line=%0d status=%0d",
                             rsp_ch.read_data, rsp_ch.irq_fire, rsp_ch.irq_line,
                             rsp_ch.status);
                errors++;
            end else begin
                want = pending_responses.pop_front();
                if (rsp_ch.read_data !== want.read_data || rsp_ch.irq_fire !== want.irq_fire
                    || rsp_ch.irq_line !== want.irq_line || rsp_ch.status !== want.status) begin
                    if (errors < MAX_SHOWN) begin
                        $display("mismatch: exp rdata=%0h fire=%0b line=%0d status=%0d",
                                 want.read_data, want.irq_fire, want.irq_line, want.status);
                        $display("          got rdata=%0h fire=%0b line=%0d status=%0d",
                                 rsp_ch.read_data, rsp_ch.irq_fire, rsp_ch.irq_line,
                                 rsp_ch.status);
                    end
                    errors++;
                end
            end
        end
    end

    function automatic t_result apply_request(input logic [2:0] req, input logic [3:0] pin,
                                              input logic [7:0] wdata, input logic [1:0] lvl);
        t_result    r;
        logic [7:0] conf;
        logic [1:0] prev;
        logic       hit;
        r = '0;
        conf = pin_conf_q[pin];
        prev = pin_level_q[pin];
        case (req)
            REQ_LVL_RD: begin
                r.read_data = {6'b0, prev};
            end
            REQ_LVL_WR: begin
                if (wdata > LVL_MAX)
                    r.status = ST_BAD_LEVEL;
                else
                    pin_level_q[pin] = wdata[1:0];
            end
            REQ_CONF_RD: begin
                r.read_data = conf;
            end
            REQ_CONF_WR: begin
                if (((conf ^ wdata) & CONF_PULL_MASK) != 8'd0)
                    r.status = ST_PULL_REFUSED;
                else
                    pin_conf_q[pin] = wdata;
            end
            REQ_PIN_EVT: begin
                if (lvl == LVL_ILLEGAL) begin
                    r.status = ST_BAD_LEVEL;
                end else begin
                    pin_level_q[pin] = lvl;
                    hit = (lvl == LVL_LOW && (conf[CONF_INT_LVL_LOW]
                              || (prev != LVL_LOW && conf[CONF_INT_EDGE_LOW])))
                       || (lvl == LVL_HIGH && (conf[CONF_INT_LVL_HIGH]
                              || (prev != LVL_HIGH && conf[CONF_INT_EDGE_HIGH])));
                    if (hit) begin
                        r.irq_fire = 1'b1;
                        r.irq_line = coalesce_q ? 4'd0 : pin;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input logic [2:0] req, input logic [3:0] pin,
                                input logic [7:0] wdata, input logic [1:0] lvl);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 3);
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= req;
        req_ch.pin_index  <= pin;
        req_ch.write_data <= wdata;
        req_ch.pin_level  <= lvl;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_responses.push_back(apply_request(req, pin, wdata, lvl));
    endtask

    task automatic drain_requests();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (RSP_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic set_coalesce(input logic mode);
        drain_requests();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        coalesce_q = mode;
    endtask

    task automatic test_level_access();
        send_request(REQ_LVL_RD, 4'd0, 8'd0, LVL_FLOAT);
        send_request(REQ_LVL_WR, 4'd15, {6'b0, LVL_HIGH}, LVL_FLOAT);
        send_request(REQ_LVL_RD, 4'd15, 8'd0, LVL_FLOAT);
        send_request(REQ_LVL_WR, 4'd3, 8'hff, LVL_FLOAT);
        send_request(REQ_LVL_WR, 4'd3, {6'b0, LVL_ILLEGAL}, LVL_FLOAT);
        send_request(REQ_LVL_RD, 4'd3, 8'd0, LVL_FLOAT);
    endtask

    task automatic test_conf_access();
        send_request(REQ_CONF_RD, 4'd15, 8'd0, LVL_FLOAT);
        send_request(REQ_CONF_WR, 4'd1, 8'h02, LVL_FLOAT);
        send_request(REQ_CONF_WR, 4'd1, 8'h04, LVL_FLOAT);
        send_request(REQ_CONF_WR, 4'd1, 8'hf9, LVL_FLOAT);
        send_request(REQ_CONF_RD, 4'd1, 8'd0, LVL_FLOAT);
    endtask

    task automatic test_pin_events();
        send_request(REQ_PIN_EVT, 4'd1, 8'd0, LVL_ILLEGAL);
        send_request(REQ_CONF_WR, 4'd1, 8'hf9, LVL_FLOAT);
        send_request(REQ_PIN_EVT, 4'd1, 8'd0, LVL_LOW);
        send_request(REQ_PIN_EVT, 4'd1, 8'd0, LVL_LOW);
        send_request(REQ_PIN_EVT, 4'd1, 8'd0, LVL_HIGH);
        send_request(REQ_PIN_EVT, 4'd1, 8'd0, LVL_FLOAT);
        // edge-only pin: repeated levels must stay quiet
        send_request(REQ_CONF_WR, 4'd2, 8'h60, LVL_FLOAT);
        send_request(REQ_PIN_EVT, 4'd2, 8'd0, LVL_LOW);
        send_request(REQ_PIN_EVT, 4'd2, 8'd0, LVL_LOW);
        send_request(REQ_PIN_EVT, 4'd2, 8'd0, LVL_HIGH);
        send_request(REQ_PIN_EVT, 4'd2, 8'd0, LVL_HIGH);
    endtask

    task automatic test_unknown_requests();
        send_request(REQ_UNUSED_LO, 4'd4, 8'hff, LVL_ILLEGAL);
        send_request(REQ_UNUSED_HI, 4'd15, 8'hff, LVL_HIGH);
    endtask

    task automatic test_coalesced_events();
        set_coalesce(1'b1);
        send_request(REQ_PIN_EVT, 4'd1, 8'd0, LVL_HIGH);
        send_request(REQ_PIN_EVT, 4'd2, 8'd0, LVL_LOW);
    endtask

    task automatic random_request();
        int         sel;
        logic [2:0] req;
        logic [3:0] pin;
        logic [7:0] wdata;
        logic [1:0] lvl;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            req = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        else if (sel < 15)
            req = REQ_LVL_RD;
        else if (sel < 27)
            req = REQ_LVL_WR;
        else if (sel < 37)
            req = REQ_CONF_RD;
        else if (sel < 55)
            req = REQ_CONF_WR;
        else
            req = REQ_PIN_EVT;
        pin = $urandom_range(0, 1) ? 4'($urandom_range(0, 3))
                                   : 4'($urandom_range(0, PINS - 1));
        wdata = 8'($urandom_range(0, 255));
        if (req == REQ_LVL_WR && $urandom_range(0, 3) != 0)
            wdata = 8'($urandom_range(0, LVL_MAX));
        // keep the pull bits most of the time so the write lands
        if (req == REQ_CONF_WR && $urandom_range(0, 4) != 0)
            wdata = (wdata & ~CONF_PULL_MASK) | (pin_conf_q[pin] & CONF_PULL_MASK);
        lvl = ($urandom_range(0, 15) == 0) ? LVL_ILLEGAL : 2'($urandom_range(0, LVL_HIGH));
        send_request(req, pin, wdata, lvl);
    endtask

    task automatic test_random_traffic(input int count, input logic mode, input bit quiet);
        set_coalesce(mode);
        no_idle = quiet;
        repeat (count) random_request();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_LVL_RD;
        req_ch.pin_index  = 4'd0;
        req_ch.write_data = 8'd0;
        req_ch.pin_level  = LVL_FLOAT;
        no_idle           = 1'b0;
        coalesce_q        = 1'b0;
        for (int i = 0; i < PINS; i++) begin
            pin_level_q[i] = LVL_FLOAT;
            pin_conf_q[i]  = 8'd0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_level_access();
        test_conf_access();
        test_pin_events();
        test_unknown_requests();
        test_coalesced_events();
        test_random_traffic(RANDOM_ITEMS * 7 / 20, 1'b0, 1'b0);
        test_random_traffic(RANDOM_ITEMS * 7 / 20, 1'b1, 1'b0);
        test_random_traffic(RANDOM_ITEMS * 3 / 10, 1'b0, 1'b1);

        drain_requests();
        if (errors == 0 && pending_responses.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/gbpi_pkg.sv
rtl/core/gbpi_if.sv
rtl/core/gbpi_pin_ram.sv
rtl/core/gbpi_rmw.sv
rtl/core/gpio_bank_with_pin_interrupts.sv
rtl/core/gbpi_checker.sv
tb/gpio_bank_with_pin_interrupts_tb.sv
